/* hdl/cpm_pkg.sv */
// Shared types and constants of the cyclic polynomial multiplier.
package cpm_pkg;

  // Field widths of the request and result channels
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 9;
  localparam int COEFF_W = 16;
  localparam int RES_W   = 16;

  // Accumulator width; sums wrap at this width
  localparam int ACC_W   = 48;

  // Configuration register widths
  localparam int Q_W     = 17;
  localparam int PB_W    = 5;

  // APB port geometry
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Request modes
  localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACC_A  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd3;

  // Configuration register indexes (word address)
  localparam logic [1:0] REG_REDUCE_SELECT = 2'd0;
  localparam logic [1:0] REG_MODULUS_Q     = 2'd1;
  localparam logic [1:0] REG_POW2_BITS     = 2'd2;

  // Register reset values
  localparam logic [Q_W-1:0]  MODULUS_Q_RST = 17'd2048;
  localparam logic [PB_W-1:0] POW2_BITS_RST = 5'd11;

  // Largest power-of-two exponent that still fits the result field
  localparam logic [PB_W-1:0] POW2_BITS_MAX = 5'd16;

  typedef struct packed {
    logic            reduce_select;
    logic [Q_W-1:0]  modulus_q;
    logic [PB_W-1:0] pow2_bits;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [IDX_W-1:0]          index;
    logic signed [COEFF_W-1:0] coeff;
  } cmd_t;

  // Accumulator fetch handed to the reduction unit
  typedef struct packed {
    logic             start;
    logic             oor;
    logic [ACC_W-1:0] acc;
  } red_req_t;

endpackage

/* hdl/cpm_if.sv */
// Valid/ready channel interfaces for requests and results.
interface cpm_in_if;
  logic                               valid;
  logic                               ready;
  logic [cpm_pkg::MODE_W-1:0]         mode;
  logic [cpm_pkg::IDX_W-1:0]          index;
  logic signed [cpm_pkg::COEFF_W-1:0] coeff;

  modport source (output valid, mode, index, coeff, input ready);
  modport sink   (input valid, mode, index, coeff, output ready);
endinterface

interface cpm_out_if;
  logic                      valid;
  logic                      ready;
  logic [cpm_pkg::RES_W-1:0] result;

  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

/* hdl/cyclic_poly_mul_mod.sv */
// Cyclic polynomial multiplier over Z[x]/(x^DEGREE - 1) with modular readout.
//
// Requests arrive on in_ch (valid/ready); each carries mode, index and coeff.
//   Load B (mode 0): stores coeff at index; no result.
//   Accumulate A (mode 1): sweeps all DEGREE accumulators, one memory
//     read-modify-write per cycle; no result.
//   Read (mode 2): one result on out_ch, reduced modulo q by a 48-step
//     bit-serial remainder or masked in power-of-two mode; zero for an
//     index beyond DEGREE or a modulus q below 2.
//   Clear (mode 3): zeroes the accumulators; B is kept.
// One request is in work at a time; the accumulator memory port sets the
// accumulate rate. Results leave through an output register, so the next
// request is taken while a result waits. A stalled receiver holds the
// result; a second read then waits in the reduction unit.
// After reset a pass clears the accumulators while in_ch.ready stays low;
// the B memory is undefined until loaded. Registers (APB, cfg_*) are to
// be written only while the block is idle; the block does not enforce it.
module cyclic_poly_mul_mod #(
  parameter int DEGREE = 512
) (
  input  logic                           clk,
  input  logic                           rst_n,
  cpm_in_if.sink                         in_ch,
  cpm_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cpm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [cpm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [cpm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);

  cpm_pkg::cfg_t             cfg;
  cpm_pkg::cmd_t             cmd;
  cpm_pkg::red_req_t         red_req;
  logic                      core_idle;
  logic                      red_busy;
  logic                      start;
  logic                      res_valid;
  logic                      res_ready;
  logic [cpm_pkg::RES_W-1:0] res;
  logic                      out_valid_r;
  logic [cpm_pkg::RES_W-1:0] out_result_r;

  cpm_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Take a request only when both the sweep and the reduction are free
  assign in_ch.ready = core_idle && !red_busy;
  assign start       = in_ch.valid && in_ch.ready;
  assign cmd.mode    = in_ch.mode;
  assign cmd.index   = in_ch.index;
  assign cmd.coeff   = in_ch.coeff;

  cpm_core #(
    .DEGREE (DEGREE)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cmd     (cmd),
    .idle    (core_idle),
    .red_req (red_req)
  );

  cpm_reduce u_reduce (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (red_req),
    .cfg       (cfg),
    .busy      (red_busy),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_result_r <= res;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.result = out_result_r;

endmodule

/* hdl/cpm_cfg.sv */
// APB configuration registers of the cyclic polynomial multiplier.
module cpm_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [cpm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [cpm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  output cpm_pkg::cfg_t                  cfg
);

  cpm_pkg::cfg_t cfg_r;
  logic          wr_en;
  logic [1:0]    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[3:2];
  assign cfg     = cfg_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reduce_select <= 1'b0;
      cfg_r.modulus_q     <= cpm_pkg::MODULUS_Q_RST;
      cfg_r.pow2_bits     <= cpm_pkg::POW2_BITS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        cpm_pkg::REG_REDUCE_SELECT: cfg_r.reduce_select <= pwdata[0];
        cpm_pkg::REG_MODULUS_Q:     cfg_r.modulus_q     <= pwdata[cpm_pkg::Q_W-1:0];
        cpm_pkg::REG_POW2_BITS:     cfg_r.pow2_bits     <= pwdata[cpm_pkg::PB_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_sel)
      cpm_pkg::REG_REDUCE_SELECT: prdata = cpm_pkg::CFG_DATA_W'(cfg_r.reduce_select);
      cpm_pkg::REG_MODULUS_Q:     prdata = cpm_pkg::CFG_DATA_W'(cfg_r.modulus_q);
      cpm_pkg::REG_POW2_BITS:     prdata = cpm_pkg::CFG_DATA_W'(cfg_r.pow2_bits);
      default:                    prdata = '0;
    endcase
  end

endmodule

/* hdl/cpm_core.sv */
// Coefficient and accumulator memories with the multiply-accumulate sweep.
module cpm_core #(
  parameter int DEGREE = 512
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  cpm_pkg::cmd_t     cmd,
  output logic              idle,
  output cpm_pkg::red_req_t red_req
);

  localparam int AW = (DEGREE > 2) ? $clog2(DEGREE) : 1;
  localparam int CW = ((AW > cpm_pkg::IDX_W) ? AW : cpm_pkg::IDX_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(DEGREE - 1);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ACC   = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  localparam int AW_ACC = cpm_pkg::ACC_W;
  localparam int PW     = 2 * cpm_pkg::COEFF_W;

  // Memories
  logic signed [cpm_pkg::COEFF_W-1:0] b_mem   [DEGREE];
  logic [AW_ACC-1:0]                  acc_mem [DEGREE];
  logic signed [cpm_pkg::COEFF_W-1:0] b_q_r;
  logic [AW_ACC-1:0]                  acc_q_r;

  // Sequencer state
  logic [2:0]                         state_r, state_nxt;
  logic [AW-1:0]                      cnt_r, cnt_nxt;
  logic [AW-1:0]                      k_r, k_nxt;
  logic signed [cpm_pkg::COEFF_W-1:0] coeff_r, coeff_nxt;
  logic                               oor_r, oor_nxt;

  // Pipeline stages
  logic                               v1_r, v2_r;
  logic [AW-1:0]                      k1_r, k2_r;
  logic signed [PW-1:0]               prod_r;
  logic [AW_ACC-1:0]                  acc2_r;

  // Memory port controls
  logic                               issue;
  logic                               in_range;
  logic [AW-1:0]                      cmd_addr;
  logic                               b_we;
  logic [AW-1:0]                      acc_ra;
  logic                               acc_we;
  logic [AW-1:0]                      acc_wa;
  logic [AW_ACC-1:0]                  acc_wd;

  assign in_range = CW'(cmd.index) < CW'(DEGREE);
  assign cmd_addr = AW'(cmd.index);

  // Sequence clear, load, accumulate sweep and fetch
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    coeff_nxt = coeff_r;
    oor_nxt   = oor_r;
    issue     = 1'b0;
    b_we      = 1'b0;
    acc_ra    = k_r;
    acc_we    = 1'b0;
    acc_wa    = k2_r;
    acc_wd    = acc2_r + {{(AW_ACC-PW){prod_r[PW-1]}}, prod_r};
    unique case (state_r)
      S_CLEAR: begin
        acc_we  = 1'b1;
        acc_wa  = cnt_r;
        acc_wd  = '0;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (cmd.mode)
            cpm_pkg::MODE_LOAD_B: b_we = in_range;
            cpm_pkg::MODE_ACC_A: begin
              if (in_range) begin
                cnt_nxt   = '0;
                k_nxt     = cmd_addr;
                coeff_nxt = cmd.coeff;
                state_nxt = S_ACC;
              end
            end
            cpm_pkg::MODE_READ: begin
              acc_ra    = cmd_addr;
              oor_nxt   = !in_range;
              state_nxt = S_READ;
            end
            cpm_pkg::MODE_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_ACC: begin
        issue   = 1'b1;
        cnt_nxt = cnt_r + 1'b1;
        k_nxt   = (k_r == LAST) ? '0 : k_r + 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last write-back lands at this edge once stage one is empty
        if (!v1_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_READ: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // write back the running sum
    if (v2_r) begin
      acc_we = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cnt_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
    end
  end

  // Payload registers and multiply stage
  always_ff @(posedge clk) begin
    k_r     <= k_nxt;
    coeff_r <= coeff_nxt;
    oor_r   <= oor_nxt;
    k1_r    <= k_r;
    k2_r    <= k1_r;
    prod_r  <= PW'(coeff_r) * PW'(b_q_r);
    acc2_r  <= acc_q_r;
  end

  // B coefficient memory
  always_ff @(posedge clk) begin
    if (b_we) begin
      b_mem[cmd_addr] <= cmd.coeff;
    end
    b_q_r <= b_mem[cnt_r];
  end

  // Accumulator memory
  always_ff @(posedge clk) begin
    if (acc_we) begin
      acc_mem[acc_wa] <= acc_wd;
    end
    acc_q_r <= acc_mem[acc_ra];
  end

  assign idle          = (state_r == S_IDLE);
  assign red_req.start = (state_r == S_READ);
  assign red_req.oor   = oor_r;
  assign red_req.acc   = acc_q_r;

endmodule

/* hdl/cpm_reduce.sv */
// Result reduction: power-of-two mask or bit-serial signed remainder mod q.
module cpm_reduce (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cpm_pkg::red_req_t         req,
  input  cpm_pkg::cfg_t             cfg,
  output logic                      busy,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [cpm_pkg::RES_W-1:0] res
);

  localparam int ACC_W = cpm_pkg::ACC_W;
  localparam int Q_W   = cpm_pkg::Q_W;
  localparam int CNT_W = $clog2(ACC_W);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_DIV  = 2'd1;
  localparam logic [1:0] R_FIX  = 2'd2;
  localparam logic [1:0] R_HOLD = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ACC_W-1:0]         mag_r, mag_nxt;
  logic [Q_W-1:0]           rem_r, rem_nxt;
  logic                     neg_r, neg_nxt;
  logic [cpm_pkg::RES_W-1:0] res_r, res_nxt;

  logic [Q_W:0]             trial;
  logic [Q_W:0]             q_ext;
  logic [cpm_pkg::PB_W-1:0] bits_c;
  logic [cpm_pkg::RES_W:0]  mask_w;
  logic [Q_W-1:0]           fix_w;

  assign trial  = {rem_r, mag_r[ACC_W-1]};
  assign q_ext  = {1'b0, cfg.modulus_q};
  assign bits_c = (cfg.pow2_bits > cpm_pkg::POW2_BITS_MAX) ? cpm_pkg::POW2_BITS_MAX
                                                           : cfg.pow2_bits;
  assign mask_w = ({{cpm_pkg::RES_W{1'b0}}, 1'b1} << bits_c) - 1'b1;
  assign fix_w  = (neg_r && (rem_r != '0)) ? cfg.modulus_q - rem_r : rem_r;

  // Reduce one fetched accumulator
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mag_nxt   = mag_r;
    rem_nxt   = rem_r;
    neg_nxt   = neg_r;
    res_nxt   = res_r;
    unique case (state_r)
      R_IDLE: begin
        if (req.start) begin
          state_nxt = R_HOLD;
          if (req.oor) begin
            res_nxt = '0;
          end else if (cfg.reduce_select) begin
            res_nxt = req.acc[cpm_pkg::RES_W-1:0] & mask_w[cpm_pkg::RES_W-1:0];
          end else if (cfg.modulus_q < Q_W'(2)) begin
            res_nxt = '0;
          end else begin
            // divide the magnitude, fix the sign afterwards
            neg_nxt   = req.acc[ACC_W-1];
            mag_nxt   = req.acc[ACC_W-1] ? (~req.acc + 1'b1) : req.acc;
            rem_nxt   = '0;
            cnt_nxt   = CNT_W'(ACC_W - 1);
            state_nxt = R_DIV;
          end
        end
      end
      R_DIV: begin
        rem_nxt = (trial >= q_ext) ? Q_W'(trial - q_ext) : trial[Q_W-1:0];
        mag_nxt = {mag_r[ACC_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = R_FIX;
        end
      end
      R_FIX: begin
        res_nxt   = fix_w[cpm_pkg::RES_W-1:0];
        state_nxt = R_HOLD;
      end
      R_HOLD: begin
        if (res_ready) begin
          state_nxt = R_IDLE;
        end
      end
      default: state_nxt = R_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign busy      = (state_r != R_IDLE);
  assign res_valid = (state_r == R_HOLD);
  assign res       = res_r;

endmodule

/* hdl/cpm_checker.sv */
// Port-level checks of the cyclic polynomial multiplier, bound to the top level.
module cpm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [cpm_pkg::MODE_W-1:0] in_mode,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [cpm_pkg::RES_W-1:0]  out_result
);

  logic       in_acc;
  logic       rd_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign rd_acc  = in_acc && (in_mode == cpm_pkg::MODE_READ);
  assign out_acc = out_valid && out_ready;

  // Track reads whose result is not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (rd_acc && !out_acc) begin
      pend_r <= pend_r + 1'b1;
    end else if (!rd_acc && out_acc) begin
      pend_r <= pend_r - 1'b1;
    end
  end

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed while stalled");

  // No result right after reset
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Read and clear requests keep the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_mode == cpm_pkg::MODE_READ || in_mode == cpm_pkg::MODE_CLEAR)
      |=> !in_ready)
    else $error("request taken while previous one in work");

  // Every result answers an outstanding read
  a_out_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a pending read");

  // At most one result waits and one is in reduction
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("too many reads outstanding");

endmodule

bind cyclic_poly_mul_mod cpm_checker u_cpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_mode    (in_ch.mode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result)
);
